// ===== rtl/mus_to_midi_event_parser_assert.svh =====
// ----------------------------------------------------------------------------
// mus_to_midi_event_parser assertion macros
// concurrent checks on clk, with and without the rst_n disable
// ----------------------------------------------------------------------------
`ifndef MUS_TO_MIDI_EVENT_PARSER_ASSERT_SVH
`define MUS_TO_MIDI_EVENT_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define MTM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtm assertion failed");
`define MTM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mtm reset assertion failed");
`else
`define MTM_ASSERT(lbl, prop)
`define MTM_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== rtl/mtm_pkg.sv =====
// ----------------------------------------------------------------------------
// mtm_pkg
// types, codes and tables shared by the mus to midi event parser
// ----------------------------------------------------------------------------
package mtm_pkg;

  localparam int CHANNELS      = 16;
  localparam int CH_BITS       = $clog2(CHANNELS);
  localparam int TIME_BITS_DEF = 32;
  localparam int MID_DEPTH     = 2;
  localparam int OUT_DEPTH     = 2;

  localparam logic [7:0] EOT_BYTE = 8'h60;

  localparam logic [2:0] EV_RELEASE = 3'd0;
  localparam logic [2:0] EV_NOTE    = 3'd1;
  localparam logic [2:0] EV_PITCH   = 3'd2;
  localparam logic [2:0] EV_SYSTEM  = 3'd3;
  localparam logic [2:0] EV_CTRL    = 3'd4;

  typedef enum logic [3:0] {
    PH_STATUS  = 4'd0,
    PH_RELEASE = 4'd1,
    PH_NOTE    = 4'd2,
    PH_VEL     = 4'd3,
    PH_PITCH   = 4'd4,
    PH_SYSTEM  = 4'd5,
    PH_CTRL    = 4'd6,
    PH_CVALUE  = 4'd7,
    PH_PROGRAM = 4'd8,
    PH_DELTA   = 4'd9
  } phase_t;

  typedef enum logic [3:0] {
    K_NOTE   = 4'd0,
    K_PITCH  = 4'd1,
    K_CTRL   = 4'd2,
    K_PROG   = 4'd3,
    K_END    = 4'd4,
    K_BADST  = 4'd5,
    K_BADSYS = 4'd6,
    K_BADCTL = 4'd7,
    K_TRUNC  = 4'd8
  } kind_t;

  typedef struct packed {
    logic               op;
    logic [7:0]         data;
    logic [CH_BITS-1:0] chan;
    logic [2:0]         ev_type;
    logic               is_eot;
    logic               sys_ok;
    logic               ctl_zero;
    logic               ctl_ok;
    logic [7:0]         map_val;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  data_count;
    logic [31:0] timestamp;
  } res_t;

  typedef struct packed {
    logic halted;
    logic consume;
    logic emit;
  } back_stat_t;

  function automatic logic [7:0] ctrl_map(input logic [3:0] idx);
    logic [7:0] v;
    unique case (idx)
      4'd2:    v = 8'd1;
      4'd3:    v = 8'd7;
      4'd4:    v = 8'd10;
      4'd5:    v = 8'd11;
      4'd6:    v = 8'd91;
      4'd7:    v = 8'd93;
      4'd8:    v = 8'd64;
      4'd9:    v = 8'd67;
      4'd10:   v = 8'd120;
      4'd11:   v = 8'd123;
      4'd12:   v = 8'd126;
      4'd13:   v = 8'd127;
      4'd14:   v = 8'd121;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // 15 goes to 9, 9..14 move up one
  function automatic logic [CH_BITS-1:0] chan_of(input logic [3:0] nib);
    logic [CH_BITS-1:0] c;
    priority if (nib == 4'd15) begin
      c = CH_BITS'(9);
    end else if (nib >= 4'd9) begin
      c = CH_BITS'(nib + 4'd1);
    end else begin
      c = CH_BITS'(nib);
    end
    return c;
  endfunction

endpackage

// ===== rtl/mtm_fifo.sv =====
// ----------------------------------------------------------------------------
// mtm_fifo
// small register queue, oldest entry shown while not empty
// ----------------------------------------------------------------------------
module mtm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rptr_r];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/mtm_front.sv =====
// ----------------------------------------------------------------------------
// mtm_front
// accepts input bytes and classifies them for the parser
// ----------------------------------------------------------------------------
module mtm_front (
  input  logic          push,
  input  logic          full,
  input  logic          op,
  input  logic [7:0]    data_byte,
  output logic          wr,
  output mtm_pkg::cmd_t cmd
);

  assign wr = push && !full;

  always_comb begin
    cmd          = '0;
    cmd.op       = op;
    cmd.data     = data_byte;
    cmd.chan     = mtm_pkg::chan_of(data_byte[3:0]);
    cmd.ev_type  = data_byte[6:4];
    cmd.is_eot   = (data_byte == mtm_pkg::EOT_BYTE);
    cmd.sys_ok   = (data_byte >= 8'd10) && (data_byte <= 8'd14);
    cmd.ctl_zero = (data_byte == 8'd0);
    cmd.ctl_ok   = (data_byte < 8'd10);
    cmd.map_val  = mtm_pkg::ctrl_map(data_byte[3:0]);
  end

endmodule

// ===== rtl/mtm_back.sv =====
// ----------------------------------------------------------------------------
// mtm_back
// event parser: phase machine, velocity memory and tick time
// ----------------------------------------------------------------------------
module mtm_back #(
  parameter int TIME_BITS = mtm_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  mtm_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_wr,
  output mtm_pkg::res_t       res,
  output mtm_pkg::back_stat_t stat
);

  localparam int CB = mtm_pkg::CH_BITS;

  mtm_pkg::phase_t  phase_r, phase_nxt;
  logic [CB-1:0]    chan_r, chan_nxt;
  logic             st7_r, st7_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [7:0]       vel_r [mtm_pkg::CHANNELS];
  logic             vel_we;
  logic [TIME_BITS-1:0] tick_r, tick_nxt;
  logic [TIME_BITS-1:0] acc_r, acc_nxt;
  logic [TIME_BITS-1:0] acc_shift;
  logic             halted_r, halted_nxt;
  logic             consume;
  logic [31:0]      ts;

  assign consume   = cmd_valid && !res_full;
  assign cmd_pop   = consume;
  assign ts        = 32'(tick_r);
  assign acc_shift = {acc_r[TIME_BITS-8:0], cmd.data[6:0]};

  always_comb begin
    phase_nxt  = phase_r;
    chan_nxt   = chan_r;
    st7_nxt    = st7_r;
    pend_nxt   = pend_r;
    tick_nxt   = tick_r;
    acc_nxt    = acc_r;
    halted_nxt = halted_r;
    vel_we     = 1'b0;
    res_wr     = 1'b0;
    res        = '0;
    res.kind       = mtm_pkg::K_END;
    res.timestamp  = ts;

    if (consume && !halted_r) begin
      if (cmd.op) begin
        res_wr     = 1'b1;
        halted_nxt = 1'b1;
        phase_nxt  = mtm_pkg::PH_STATUS;
        res.kind   = (phase_r == mtm_pkg::PH_STATUS) ? mtm_pkg::K_END : mtm_pkg::K_TRUNC;
      end else begin
        unique case (phase_r)
          mtm_pkg::PH_STATUS: begin
            if (cmd.is_eot) begin
              res_wr     = 1'b1;
              halted_nxt = 1'b1;
            end else begin
              chan_nxt = cmd.chan;
              st7_nxt  = cmd.data[7];
              unique case (cmd.ev_type)
                mtm_pkg::EV_RELEASE: phase_nxt = mtm_pkg::PH_RELEASE;
                mtm_pkg::EV_NOTE:    phase_nxt = mtm_pkg::PH_NOTE;
                mtm_pkg::EV_PITCH:   phase_nxt = mtm_pkg::PH_PITCH;
                mtm_pkg::EV_SYSTEM:  phase_nxt = mtm_pkg::PH_SYSTEM;
                mtm_pkg::EV_CTRL:    phase_nxt = mtm_pkg::PH_CTRL;
                default: begin
                  res_wr     = 1'b1;
                  halted_nxt = 1'b1;
                  res.kind   = mtm_pkg::K_BADST;
                end
              endcase
            end
          end
          mtm_pkg::PH_RELEASE: begin
            res_wr         = 1'b1;
            res.kind       = mtm_pkg::K_NOTE;
            res.first_data = cmd.data;
          end
          mtm_pkg::PH_NOTE: begin
            if (cmd.data[7]) begin
              pend_nxt  = {1'b0, cmd.data[6:0]};
              phase_nxt = mtm_pkg::PH_VEL;
            end else begin
              res_wr          = 1'b1;
              res.kind        = mtm_pkg::K_NOTE;
              res.first_data  = cmd.data;
              res.second_data = vel_r[chan_r];
            end
          end
          mtm_pkg::PH_VEL: begin
            vel_we          = 1'b1;
            res_wr          = 1'b1;
            res.kind        = mtm_pkg::K_NOTE;
            res.first_data  = pend_r;
            res.second_data = cmd.data;
          end
          mtm_pkg::PH_PITCH: begin
            res_wr          = 1'b1;
            res.kind        = mtm_pkg::K_PITCH;
            res.first_data  = {1'b0, cmd.data[0], 6'd0};
            res.second_data = {1'b0, cmd.data[7:1]};
          end
          mtm_pkg::PH_SYSTEM: begin
            res_wr = 1'b1;
            if (cmd.sys_ok) begin
              res.kind        = mtm_pkg::K_CTRL;
              res.first_data  = cmd.map_val;
              res.second_data = 8'd1;
            end else begin
              halted_nxt = 1'b1;
              phase_nxt  = mtm_pkg::PH_STATUS;
              res.kind   = mtm_pkg::K_BADSYS;
            end
          end
          mtm_pkg::PH_CTRL: begin
            priority if (cmd.ctl_zero) begin
              phase_nxt = mtm_pkg::PH_PROGRAM;
            end else if (cmd.ctl_ok) begin
              pend_nxt  = cmd.map_val;
              phase_nxt = mtm_pkg::PH_CVALUE;
            end else begin
              res_wr     = 1'b1;
              halted_nxt = 1'b1;
              phase_nxt  = mtm_pkg::PH_STATUS;
              res.kind   = mtm_pkg::K_BADCTL;
            end
          end
          mtm_pkg::PH_CVALUE: begin
            res_wr          = 1'b1;
            res.kind        = mtm_pkg::K_CTRL;
            res.first_data  = pend_r;
            res.second_data = cmd.data;
          end
          mtm_pkg::PH_PROGRAM: begin
            res_wr         = 1'b1;
            res.kind       = mtm_pkg::K_PROG;
            res.first_data = cmd.data;
          end
          mtm_pkg::PH_DELTA: begin
            if (cmd.data[7]) begin
              acc_nxt = acc_shift;
            end else begin
              tick_nxt  = tick_r + acc_shift;
              acc_nxt   = '0;
              phase_nxt = mtm_pkg::PH_STATUS;
            end
          end
          default: phase_nxt = mtm_pkg::PH_STATUS;
        endcase

        // completed channel event
        if (res_wr && (res.kind == mtm_pkg::K_NOTE || res.kind == mtm_pkg::K_PITCH ||
                       res.kind == mtm_pkg::K_CTRL || res.kind == mtm_pkg::K_PROG)) begin
          res.channel    = 4'(chan_r);
          res.data_count = (res.kind == mtm_pkg::K_PROG) ? 2'd1 : 2'd2;
          phase_nxt      = st7_r ? mtm_pkg::PH_DELTA : mtm_pkg::PH_STATUS;
          acc_nxt        = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mtm_pkg::PH_STATUS;
      chan_r   <= '0;
      st7_r    <= 1'b0;
      pend_r   <= '0;
      tick_r   <= '0;
      acc_r    <= '0;
      halted_r <= 1'b0;
      for (int i = 0; i < mtm_pkg::CHANNELS; i++) begin
        vel_r[i] <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      chan_r   <= chan_nxt;
      st7_r    <= st7_nxt;
      pend_r   <= pend_nxt;
      tick_r   <= tick_nxt;
      acc_r    <= acc_nxt;
      halted_r <= halted_nxt;
      if (vel_we) begin
        vel_r[chan_r] <= cmd.data;
      end
    end
  end

  assign stat.halted  = halted_r;
  assign stat.consume = consume;
  assign stat.emit    = res_wr;

endmodule

// ===== rtl/mus_to_midi_event_parser.sv =====
// ----------------------------------------------------------------------------
// mus_to_midi_event_parser
// mus score body bytes in, midi channel events out
//
//   channel  ports                                      transaction when
//   input    push full in_op in_data_byte               push && !full
//   result   pop empty out_kind out_channel out_first_data
//            out_second_data out_data_count out_timestamp  pop && !empty
//
// one byte per cycle sustained if the result queue has room; the classifier
// writes bytes to the command queue, the parser results to the result queue
// the parser step (phase machine, velocity memory, tick adder) sets the rate
// synchronous reset clears both queues, the phase, velocities and tick time
// a full result queue stalls the parser; the command queue then fills and
// raises full, each side stalling independently
// ----------------------------------------------------------------------------
`include "mus_to_midi_event_parser_assert.svh"

module mus_to_midi_event_parser #(
  parameter int TIME_BITS = mtm_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_kind,
  output logic [3:0]  out_channel,
  output logic [7:0]  out_first_data,
  output logic [7:0]  out_second_data,
  output logic [1:0]  out_data_count,
  output logic [31:0] out_timestamp
);

  localparam int CMD_W = $bits(mtm_pkg::cmd_t);
  localparam int RES_W = $bits(mtm_pkg::res_t);

  logic                mid_wr, mid_full, mid_empty, mid_rd;
  mtm_pkg::cmd_t       front_cmd, back_cmd;
  logic [CMD_W-1:0]    mid_rd_data;
  logic                res_wr, res_full;
  mtm_pkg::res_t       back_res, out_res;
  logic [RES_W-1:0]    out_rd_data;
  mtm_pkg::back_stat_t bk_stat;
  logic                stop_emit;

  assign full = mid_full;

  mtm_front u_front (
    .push      (push),
    .full      (mid_full),
    .op        (in_op),
    .data_byte (in_data_byte),
    .wr        (mid_wr),
    .cmd       (front_cmd)
  );

  mtm_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (mtm_pkg::MID_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (mid_wr),
    .wr_data (front_cmd),
    .full    (mid_full),
    .rd      (mid_rd),
    .rd_data (mid_rd_data),
    .empty   (mid_empty)
  );

  assign back_cmd = mtm_pkg::cmd_t'(mid_rd_data);

  mtm_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!mid_empty),
    .cmd       (back_cmd),
    .cmd_pop   (mid_rd),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res       (back_res),
    .stat      (bk_stat)
  );

  mtm_fifo #(
    .WIDTH (RES_W),
    .DEPTH (mtm_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (res_wr),
    .wr_data (back_res),
    .full    (res_full),
    .rd      (pop),
    .rd_data (out_rd_data),
    .empty   (empty)
  );

  assign out_res         = mtm_pkg::res_t'(out_rd_data);
  assign out_kind        = out_res.kind;
  assign out_channel     = out_res.channel;
  assign out_first_data  = out_res.first_data;
  assign out_second_data = out_res.second_data;
  assign out_data_count  = out_res.data_count;
  assign out_timestamp   = out_res.timestamp;

  assign stop_emit = bk_stat.emit && (back_res.kind == mtm_pkg::K_END ||
                     back_res.kind == mtm_pkg::K_TRUNC || back_res.kind == mtm_pkg::K_BADST);

  `MTM_ASSERT(a_silent_when_halted, bk_stat.halted |-> !bk_stat.emit)
  `MTM_ASSERT(a_no_res_overflow, res_wr |-> !res_full && bk_stat.consume)
  `MTM_ASSERT(a_stop_halts, stop_emit |=> bk_stat.halted)
  `MTM_ASSERT_RST(a_reset_empties, !rst_n |=> empty && !full)

endmodule
